// File: hw/rtl/lurs_pkg.sv
// Shared types and constants for the least-used random selector.
// No dependencies; imported by the selector top level.
package lurs_pkg;

  // Default number of counter slots
  localparam int MAX_ENTRIES_DEF = 32;

  // Field widths fixed by the interface
  localparam int RAND_W  = 16;
  localparam int COUNT_W = 8;
  localparam int INDEX_W = 5;
  localparam int CFG_W   = 6;

  // Counter saturation value and active-count reset value
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'hff;
  localparam logic [CFG_W-1:0]   ENTRIES_RESET = 6'd18;

  // Selector sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RANK,
    ST_PICK,
    ST_WRITE
  } sel_state_t;

endpackage

// File: hw/rtl/lurs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the per-entry use counters of the selector.
module lurs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/least_used_random_selector.sv
// Least-used entry selector with random tie break: top level.
// Depends on lurs_pkg and lurs_ram (counter storage).
//
// Each request runs over the counter RAM twice through one read port.
// With n active entries (entries_in_use, clamped to 1..min(63, MAX_ENTRIES)),
// a request is accepted, all n counters are scanned for the minimum and its
// tie count, the random word is scaled into a rank, the tied entries are
// walked in index order up to the chosen one, and the incremented counter
// is written back. The write-back also waits for as long as the previous
// result is still held on the output. The passes are serial because of the
// single RAM read port. The input is not ready while a request is in
// progress. Counters read as zero after reset through a valid bit per
// entry, so no clearing pass is needed. Only entries below 63 can ever be
// active, so storage beyond that is not built.
module least_used_random_selector #(
  parameter int MAX_ENTRIES = lurs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration: entries_in_use
  input  logic                      cfg_wr_en,
  input  logic [lurs_pkg::CFG_W-1:0] cfg_wr_data,
  // Request stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [15:0]               s_tdata,  // [15:0] random_value
  // Result stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata   // [4:0] chosen_index, [12:5] new_use_count
);

  import lurs_pkg::*;

  // Entries that can ever be active, and derived widths
  localparam int N_MAX  = (MAX_ENTRIES < 63) ? MAX_ENTRIES : 63;
  localparam int ADDR_W = $clog2(N_MAX);
  localparam int CNT_W  = $clog2(N_MAX + 1);
  localparam logic [CFG_W-1:0] N_MAX_CFG = CFG_W'(N_MAX);

  sel_state_t state, state_next;

  logic [CFG_W-1:0]   entries_in_use;
  logic [CNT_W-1:0]   n_act;
  logic [RAND_W-1:0]  rnd;
  logic [CNT_W-1:0]   idx;
  logic               rd_pend;
  logic [ADDR_W-1:0]  rd_idx;
  logic [COUNT_W-1:0] min_val;
  logic [CNT_W-1:0]   ties;
  logic [CNT_W-1:0]   rank;
  logic [CNT_W-1:0]   seen;
  logic [ADDR_W-1:0]  pick;
  logic [INDEX_W-1:0] chosen_index;
  logic [COUNT_W-1:0] new_use_count;

  logic [N_MAX-1:0]   written;
  logic               vld_q;
  logic [COUNT_W-1:0] ram_q;
  logic [COUNT_W-1:0] cur_val;
  logic [COUNT_W-1:0] upd_val;
  logic [CFG_W-1:0]   n_clamp;
  logic [RAND_W+CNT_W-1:0] prod;
  logic [ADDR_W+INDEX_W-1:0] pick_ext;

  // Sequencer controls
  logic issue;
  logic scan_done;
  logic hit;
  logic out_free;
  logic wr_en;
  logic accept;

  // Clamp the active count to 1..N_MAX
  always_comb begin
    if (entries_in_use == '0) begin
      n_clamp = CFG_W'(1);
    end else if (entries_in_use > N_MAX_CFG) begin
      n_clamp = N_MAX_CFG;
    end else begin
      n_clamp = entries_in_use;
    end
  end

  // Counter value returned by the last read; unwritten entries read as zero
  assign cur_val = vld_q ? ram_q : '0;
  assign upd_val = (min_val == COUNT_MAX) ? min_val : min_val + COUNT_W'(1);
  assign prod    = (RAND_W+CNT_W)'(rnd) * (RAND_W+CNT_W)'(ties);
  assign pick_ext = {{INDEX_W{1'b0}}, pick};
  assign accept  = s_tvalid && s_tready;

  // Output decode of the sequencer
  always_comb begin
    s_tready  = 1'b0;
    issue     = 1'b0;
    scan_done = 1'b0;
    hit       = 1'b0;
    out_free  = !m_tvalid || m_tready;
    wr_en     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_SCAN: begin
        issue     = idx < n_act;
        scan_done = (idx == n_act) && !rd_pend;
      end
      ST_PICK: begin
        issue = idx < n_act;
        hit   = rd_pend && (cur_val == min_val) && (seen == rank);
      end
      ST_WRITE: begin
        wr_en = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_SCAN;
      ST_SCAN:  if (scan_done) state_next = ST_RANK;
      ST_RANK:  state_next = ST_PICK;
      ST_PICK:  if (hit) state_next = ST_WRITE;
      ST_WRITE: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entries_in_use <= ENTRIES_RESET;
      written        <= '0;
      m_tvalid       <= 1'b0;
      rd_pend        <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (cfg_wr_en) begin
        entries_in_use <= cfg_wr_data;
      end
      if (wr_en) begin
        written[pick] <= 1'b1;
      end
      // Drop the result on transfer, raise it on write-back
      if (wr_en) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (issue) begin
      vld_q  <= written[idx[ADDR_W-1:0]];
      rd_idx <= idx[ADDR_W-1:0];
      idx    <= idx + CNT_W'(1);
    end
    case (state)
      ST_IDLE: begin
        if (accept) begin
          rnd     <= s_tdata[RAND_W-1:0];
          n_act   <= n_clamp[CNT_W-1:0];
          idx     <= '0;
          min_val <= COUNT_MAX;
          ties    <= '0;
        end
      end
      ST_SCAN: begin
        // Track the minimum and how many entries hold it
        if (rd_pend) begin
          if (cur_val < min_val) begin
            min_val <= cur_val;
            ties    <= CNT_W'(1);
          end else if (cur_val == min_val) begin
            ties <= ties + CNT_W'(1);
          end
        end
      end
      ST_RANK: begin
        rank <= prod[RAND_W+CNT_W-1:RAND_W];
        idx  <= '0;
        seen <= '0;
      end
      ST_PICK: begin
        // Walk tied entries in index order until the rank is reached
        if (rd_pend && (cur_val == min_val)) begin
          if (seen == rank) begin
            pick <= rd_idx;
          end else begin
            seen <= seen + CNT_W'(1);
          end
        end
      end
      ST_WRITE: begin
        if (wr_en) begin
          chosen_index  <= pick_ext[INDEX_W-1:0];
          new_use_count <= upd_val;
        end
      end
      default: begin
        rank <= rank;
      end
    endcase
  end

  assign m_tdata = {3'b000, new_use_count, chosen_index};

  // Use counter storage
  lurs_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (N_MAX)
  ) u_counts (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pick),
    .wr_data (upd_val),
    .rd_en   (issue),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (ram_q)
  );

endmodule

// File: tb/least_used_random_selector_check.sv
`timescale 1ns / 1ps
// Checker for least_used_random_selector: tracks the use counters, predicts
// each selection and compares the result stream. Depends on lurs_pkg.
module least_used_random_selector_check
  import lurs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [15:0]      s_tdata,   // [15:0] random_value
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [15:0]      m_tdata,   // [4:0] chosen_index, [12:5] new_use_count
  output int               failures,
  output int               outstanding
);

  localparam int SLOTS = MAX_ENTRIES_DEF;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] count;
  } selection_t;

  // Mirror of the counter table and the active-entry register
  logic [COUNT_W-1:0] usage [SLOTS];
  logic [CFG_W-1:0]   entries_setting;
  selection_t         awaited_picks [$];

  // Pick the least-used active entry, break ties by the random word, bump it
  function automatic selection_t pick_least_used(input logic [RAND_W-1:0] word);
    int         span;
    int         lowest;
    int         ties = 0;
    int         rank;
    int         seen = 0;
    int         pick = 0;
    selection_t sel;
    span = int'(entries_setting);
    if (span < 1) span = 1;
    if (span > SLOTS) span = SLOTS;
    lowest = int'(COUNT_MAX);
    for (int k = 0; k < span; k++) begin
      if (int'(usage[k]) < lowest) lowest = int'(usage[k]);
    end
    for (int k = 0; k < span; k++) begin
      if (int'(usage[k]) == lowest) ties++;
    end
    rank = (int'(word) * ties) >> 16;
    // Walk the tied entries in index order up to the chosen rank
    for (int k = 0; k < span; k++) begin
      if (int'(usage[k]) == lowest) begin
        if (seen == rank) begin
          pick = k;
          break;
        end
        seen++;
      end
    end
    // Saturate at the top of the counter range
    if (usage[pick] != COUNT_MAX) usage[pick] = usage[pick] + 1'b1;
    sel.index = INDEX_W'(pick);
    sel.count = usage[pick];
    return sel;
  endfunction

  // Track configuration, compare results, queue new predictions
  always @(posedge clk) begin : watch
    selection_t want;
    int         errs;
    errs = failures;
    if (rst) begin
      foreach (usage[k]) usage[k] = '0;
      entries_setting = ENTRIES_RESET;
      awaited_picks.delete();
    end else begin
      if (cfg_wr_en) entries_setting = cfg_wr_data;
      if (m_tvalid && m_tready) begin
        if (awaited_picks.size() == 0) begin
          $display("%0t: unexpected transfer, index %0d count %0d", $time,
                   m_tdata[INDEX_W-1:0], m_tdata[INDEX_W+COUNT_W-1:INDEX_W]);
          errs++;
        end else begin
          want = awaited_picks.pop_front();
          if (m_tdata[INDEX_W-1:0] !== want.index) begin
            $display("%0t: chosen_index expected %0d actual %0d", $time,
                     want.index, m_tdata[INDEX_W-1:0]);
            errs++;
          end
          if (m_tdata[INDEX_W+COUNT_W-1:INDEX_W] !== want.count) begin
            $display("%0t: new_use_count expected %0d actual %0d", $time,
                     want.count, m_tdata[INDEX_W+COUNT_W-1:INDEX_W]);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_picks.push_back(pick_least_used(s_tdata[RAND_W-1:0]));
      end
    end
    failures    <= errs;
    outstanding <= awaited_picks.size();
  end

endmodule

// File: tb/least_used_random_selector_test.sv
`timescale 1ns / 1ps
// Top of the least_used_random_selector testbench: clock, reset, stimulus
// and verdict. Depends on lurs_pkg, the selector RTL and its checker.
module least_used_random_selector_test;
  import lurs_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [15:0]      s_tdata = '0;   // [15:0] random_value
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [15:0]      m_tdata;        // [4:0] chosen_index, [12:5] new_use_count
  int               failures;
  int               outstanding;
  bit               send_gaps = 1'b1;
  bit               recv_stalls = 1'b1;

  least_used_random_selector i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  least_used_random_selector_check i_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .failures   (failures),
    .outstanding(outstanding)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #20_000_000;
    $display("least_used_random_selector_test: done, errors");
    $finish;
  end

  // Result side: accept in runs, stall in random bursts
  initial begin
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (recv_stalls) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until the transfer
  task automatic send_request(input logic [15:0] word);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and hold until every selection has come back
  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_entries(input logic [CFG_W-1:0] setting);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= setting;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly uniform words, with the two extremes mixed in
  function automatic logic [15:0] draw_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] setting, input int count);
    wait_results();
    set_entries(setting);
    if (send_gaps || recv_stalls) begin
      send_gaps   = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);
    end
    repeat (count) send_request(draw_word());
  endtask

  initial begin
    logic [15:0] corner_words [8];
    corner_words = '{16'h0000, 16'hffff, 16'h8000, 16'h7fff,
                     16'h5555, 16'haaaa, 16'h0001, 16'hfffe};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Field extremes at the reset entry count
    foreach (corner_words[k]) send_request(corner_words[k]);
    // Zero active entries acts as one
    wait_results();
    set_entries(6'd0);
    send_request(16'hffff);
    send_request(16'h0000);
    // Entry counts above the table size clamp to the table size
    wait_results();
    set_entries(6'd63);
    send_request(16'hffff);
    send_request(16'h0000);
    send_request(16'h8000);
    wait_results();
    set_entries(6'd33);
    send_request(16'hffff);
    send_request(16'h0000);
    // Shrink, then widen again so idle counters keep their values
    wait_results();
    set_entries(6'd1);
    send_request(16'hffff);
    wait_results();
    set_entries(6'd32);
    send_request(16'h0000);
    send_request(16'hffff);

    // Random part; the single-entry phase drives entry 0 into saturation
    run_phase(6'd32, 200);
    run_phase(6'd1, 300);
    run_phase(6'd63, 150);
    run_phase(6'd0, 40);
    run_phase(6'd2, 80);
    repeat (8) run_phase(CFG_W'($urandom_range(1, 32)), 80);
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    run_phase(6'd32, 140);

    // Drain, then leave room for any stray transfer
    wait_results();
    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("least_used_random_selector_test: done, clean");
    end else begin
      $display("least_used_random_selector_test: done, errors");
    end
    $finish;
  end

endmodule
